/* src/pcrrb_pkg.sv */
// Package: word types, status and class codes for the job scheduler.
`timescale 1ns / 1ps
`default_nettype none
package pcrrb_pkg;

  typedef struct packed {
    logic        op;
    logic [15:0] job_tag;
    logic [2:0]  urgency;
    logic [7:0]  work_time;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        valid_job;
    logic [15:0] done_tag;
    logic [1:0]  done_urgency;
    logic [7:0]  done_time;
    logic [5:0]  batch_index;
    logic        batch_first;
    logic        last;
  } res_t;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_RUN = 1'b1;

  localparam logic [2:0] URG_HIGH = 3'd1;
  localparam logic [2:0] URG_RING = 3'd2;
  localparam logic [2:0] URG_LOW  = 3'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_URG = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  localparam logic REG_SLICE  = 1'b0;
  localparam logic REG_BUDGET = 1'b1;

  localparam logic [7:0] SLICE_RESET  = 8'd1;
  localparam logic [7:0] BUDGET_RESET = 8'd24;

endpackage
`default_nettype wire

/* src/priority_class_round_robin_batcher.sv */
// Top level: three-class job scheduler with round-robin ring and next-fit batching.
`timescale 1ns / 1ps
`default_nettype none
// An add word is handled while idle: its single result appears the next cycle and
// busy stays low. A run word raises busy and walks the stored jobs through one
// shared read/compare/subtract step: each high or low job and each ring visit
// passes a read state and then a process state, and an already completed ring
// entry is passed over in the read state on a later pass. Results come one per
// strobe on res/res_valid and cannot be held off; the receiver must take each word
// in the cycle it is shown. The last result of every command word has last set.
module priority_class_round_robin_batcher #(
  parameter int CLASS_DEPTH = 16
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  output logic              busy,
  input  wire pcrrb_pkg::cmd_t cmd,
  output pcrrb_pkg::res_t   res,
  output logic              res_valid,
  input  wire               cfg_write,
  input  wire               cfg_index,
  input  wire [7:0]         cfg_data
);
  import pcrrb_pkg::*;

  localparam int IW = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
  localparam int CW = $clog2(CLASS_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(CLASS_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HRD  = 3'd1;
  localparam logic [2:0] S_HPR  = 3'd2;
  localparam logic [2:0] S_RRD  = 3'd3;
  localparam logic [2:0] S_RPR  = 3'd4;
  localparam logic [2:0] S_LRD  = 3'd5;
  localparam logic [2:0] S_LPR  = 3'd6;

  logic [2:0]    state;
  logic [7:0]    slice_length;
  logic [7:0]    batch_budget;
  logic [CW-1:0] high_count;
  logic [CW-1:0] ring_count;
  logic [CW-1:0] low_count;
  logic [CW-1:0] alive;
  logic [IW-1:0] idx;
  logic [8:0]    batch_used;
  logic          batch_open;
  logic [5:0]    cur_index;
  logic [CLASS_DEPTH-1:0] done_flags;

  logic [23:0] high_mem [CLASS_DEPTH];
  logic [23:0] ring_mem [CLASS_DEPTH];
  logic [23:0] low_mem  [CLASS_DEPTH];
  logic [7:0]  rem_mem  [CLASS_DEPTH];
  logic [23:0] rd_high;
  logic [23:0] rd_ring;
  logic [23:0] rd_low;
  logic [7:0]  rd_rem;

  // add path
  logic          is_add;
  logic          we_high;
  logic          we_ring;
  logic          we_low;
  logic [1:0]    add_status;
  logic [23:0]   add_word;

  always_comb begin
    is_add     = start && (state == S_IDLE) && (cmd.op == OP_ADD);
    we_high    = 1'b0;
    we_ring    = 1'b0;
    we_low     = 1'b0;
    add_status = ST_OK;
    add_word   = {cmd.job_tag, cmd.work_time};
    case (cmd.urgency)
      URG_HIGH: if (high_count >= DEPTH_C) add_status = ST_FULL; else we_high = is_add;
      URG_RING: if (ring_count >= DEPTH_C) add_status = ST_FULL; else we_ring = is_add;
      URG_LOW:  if (low_count >= DEPTH_C) add_status = ST_FULL; else we_low = is_add;
      default:  add_status = ST_BAD_URG;
    endcase
  end

  // ring step
  logic [7:0]    quantum;
  logic          ring_done;
  logic          rem_we;
  logic [IW-1:0] rem_wa;
  logic [7:0]    rem_wd;
  logic [IW-1:0] idx_inc;
  logic [IW-1:0] ring_next;

  always_comb begin
    quantum   = (slice_length == 8'd0) ? 8'd1 : slice_length;
    ring_done = (rd_rem <= quantum);
    idx_inc   = IW'(idx + 1'b1);
    ring_next = (CW'(idx) + 1'b1 == ring_count) ? '0 : idx_inc;
    rem_we    = 1'b0;
    rem_wa    = idx;
    rem_wd    = rd_rem - quantum;
    if (we_ring) begin
      rem_we = 1'b1;
      rem_wa = ring_count[IW-1:0];
      rem_wd = cmd.work_time;
    end else if (state == S_RPR && !ring_done) begin
      rem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we_high) high_mem[high_count[IW-1:0]] <= add_word;
    rd_high <= high_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (we_ring) ring_mem[ring_count[IW-1:0]] <= add_word;
    rd_ring <= ring_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (we_low) low_mem[low_count[IW-1:0]] <= add_word;
    rd_low <= low_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rem_we) rem_mem[rem_wa] <= rem_wd;
    rd_rem <= rem_mem[idx];
  end

  // next-fit batching of the job now being emitted
  logic [23:0] job_word;
  logic [1:0]  job_urg;
  logic        job_over;
  logic        job_first;
  logic [5:0]  job_index;
  logic [8:0]  job_used;

  always_comb begin
    case (state)
      S_HPR:   begin job_word = rd_high; job_urg = URG_HIGH[1:0]; end
      S_RPR:   begin job_word = rd_ring; job_urg = URG_RING[1:0]; end
      default: begin job_word = rd_low;  job_urg = URG_LOW[1:0];  end
    endcase
    job_over  = (10'(batch_used) + 10'(job_word[7:0])) > 10'(batch_budget);
    job_first = !batch_open || job_over;
    job_index = !batch_open ? 6'd0 : (job_over ? cur_index + 6'd1 : cur_index);
    job_used  = 9'((job_first ? 9'd0 : batch_used) + 9'(job_word[7:0]));
  end

  logic last_high;
  logic last_ring;
  logic last_low;
  assign last_high = (CW'(idx) + 1'b1 == high_count);
  assign last_ring = (alive == CW'(1));
  assign last_low  = (CW'(idx) + 1'b1 == low_count);

  res_t job_res;
  always_comb begin
    job_res              = '0;
    job_res.status       = ST_OK;
    job_res.valid_job    = 1'b1;
    job_res.done_tag     = job_word[23:8];
    job_res.done_urgency = job_urg;
    job_res.done_time    = job_word[7:0];
    job_res.batch_index  = job_index;
    job_res.batch_first  = job_first;
    case (state)
      S_HPR:   job_res.last = last_high && (ring_count == '0) && (low_count == '0);
      S_RPR:   job_res.last = last_ring && (low_count == '0);
      default: job_res.last = last_low;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      res_valid    <= 1'b0;
      slice_length <= SLICE_RESET;
      batch_budget <= BUDGET_RESET;
      high_count   <= '0;
      ring_count   <= '0;
      low_count    <= '0;
      alive        <= '0;
      idx          <= '0;
      batch_used   <= '0;
      batch_open   <= 1'b0;
      cur_index    <= '0;
      done_flags   <= '0;
    end else begin
      res_valid <= 1'b0;
      if (cfg_write) begin
        if (cfg_index == REG_SLICE) slice_length <= cfg_data;
        if (cfg_index == REG_BUDGET) batch_budget <= cfg_data;
      end
      if (state == S_HPR || (state == S_RPR && ring_done) || state == S_LPR) begin
        res        <= job_res;
        res_valid  <= 1'b1;
        batch_open <= 1'b1;
        batch_used <= job_used;
        cur_index  <= job_index;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            res       <= '0;
            res.last  <= 1'b1;
            res_valid <= 1'b1;
            idx       <= '0;
            if (cmd.op == OP_ADD) begin
              res.status <= add_status;
              if (we_high) high_count <= high_count + 1'b1;
              if (we_ring) ring_count <= ring_count + 1'b1;
              if (we_low) low_count <= low_count + 1'b1;
            end else if (high_count == '0 && ring_count == '0 && low_count == '0) begin
              res.status <= ST_EMPTY;
            end else begin
              res_valid  <= 1'b0;
              batch_open <= 1'b0;
              batch_used <= '0;
              done_flags <= '0;
              alive      <= ring_count;
              if (high_count != '0) state <= S_HRD;
              else if (ring_count != '0) state <= S_RRD;
              else state <= S_LRD;
            end
          end
        end
        S_HRD: state <= S_HPR;
        S_HPR: begin
          if (last_high) begin
            idx <= '0;
            if (ring_count != '0) state <= S_RRD;
            else if (low_count != '0) state <= S_LRD;
            else state <= S_IDLE;
          end else begin
            idx   <= idx_inc;
            state <= S_HRD;
          end
        end
        S_RRD: begin
          if (done_flags[idx]) idx <= ring_next;
          else state <= S_RPR;
        end
        S_RPR: begin
          if (ring_done) begin
            done_flags[idx] <= 1'b1;
            alive           <= alive - 1'b1;
          end
          if (ring_done && last_ring) begin
            idx <= '0;
            if (low_count != '0) state <= S_LRD;
            else state <= S_IDLE;
          end else begin
            idx   <= ring_next;
            state <= S_RRD;
          end
        end
        S_LRD: state <= S_LPR;
        S_LPR: begin
          if (last_low) begin
            state <= S_IDLE;
          end else begin
            idx   <= idx_inc;
            state <= S_LRD;
          end
        end
        default: state <= S_IDLE;
      endcase
      // end of run: empty all classes
      if ((state == S_HPR && last_high && ring_count == '0 && low_count == '0) ||
          (state == S_RPR && ring_done && last_ring && low_count == '0) ||
          (state == S_LPR && last_low)) begin
        high_count <= '0;
        ring_count <= '0;
        low_count  <= '0;
        batch_used <= '0;
      end
    end
  end

  a_nonjob_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.valid_job |-> res.last)
    else $error("non-job result without last");

  a_job_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.valid_job |-> res.status == ST_OK)
    else $error("job result with bad status");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> res_valid && res.last && high_count == '0 && ring_count == '0 &&
                    low_count == '0)
    else $error("run ended without final word or with jobs left");

  a_ring_alive: assert property (@(posedge clk) disable iff (rst)
    (state == S_RRD || state == S_RPR) |-> alive != '0)
    else $error("ring phase with no live job");

endmodule
`default_nettype wire
